/* hw/rtl/mke_pkg.sv */
`timescale 1ns / 1ps

package mke_pkg;

	localparam int NUM_CLASSES = 12;
	localparam logic [4:0] NO_KEY = 5'd24;
	localparam logic [23:0] WEIGHT_MAX = 24'hFFFFFF;

	// profile sums and spread terms (12 * sum(p^2) - sum(p)^2), hundredths
	localparam logic [12:0] MAJ_SUM = 13'd4179;
	localparam logic [12:0] MIN_SUM = 13'd4451;
	localparam logic [42:0] MAJ_SPREAD = 43'd2297547;
	localparam logic [42:0] MIN_SPREAD = 43'd1920851;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONF_THRESH = 3'd0,
		CFG_FREQ_LOW    = 3'd1,
		CFG_FREQ_HIGH   = 3'd2,
		CFG_DECAY       = 3'd3,
		CFG_MIN_TOTAL   = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECAY,
		ST_CHECK,
		ST_MAC,
		ST_KEY,
		ST_LOAD,
		ST_MUL,
		ST_PICK
	} state_t;

	function automatic logic [9:0] major_w(input logic [3:0] i);
		logic [9:0] r;
		case (i)
			4'd0: r = 10'd635;
			4'd1: r = 10'd223;
			4'd2: r = 10'd348;
			4'd3: r = 10'd233;
			4'd4: r = 10'd438;
			4'd5: r = 10'd409;
			4'd6: r = 10'd252;
			4'd7: r = 10'd519;
			4'd8: r = 10'd239;
			4'd9: r = 10'd366;
			4'd10: r = 10'd229;
			4'd11: r = 10'd288;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

	function automatic logic [9:0] minor_w(input logic [3:0] i);
		logic [9:0] r;
		case (i)
			4'd0: r = 10'd633;
			4'd1: r = 10'd268;
			4'd2: r = 10'd352;
			4'd3: r = 10'd538;
			4'd4: r = 10'd260;
			4'd5: r = 10'd353;
			4'd6: r = 10'd254;
			4'd7: r = 10'd475;
			4'd8: r = 10'd398;
			4'd9: r = 10'd269;
			4'd10: r = 10'd334;
			4'd11: r = 10'd317;
			default: r = 10'd0;
		endcase
		return r;
	endfunction

	function automatic logic [15:0] note_edge(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0: r = 16'd34470;
			4'd1: r = 16'd36520;
			4'd2: r = 16'd38691;
			4'd3: r = 16'd40992;
			4'd4: r = 16'd43429;
			4'd5: r = 16'd46012;
			4'd6: r = 16'd48748;
			4'd7: r = 16'd51646;
			4'd8: r = 16'd54717;
			4'd9: r = 16'd57971;
			4'd10: r = 16'd61418;
			4'd11: r = 16'd65070;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

	// normalize to bit 15 (octaves keep the class), then count edges reached
	function automatic logic [3:0] pitch_class(input logic [15:0] f);
		logic [3:0] top;
		logic [15:0] m;
		logic [3:0] cnt;
		top = 4'd0;
		for (int b = 0; b < 16; b++) begin
			if (f[b]) top = 4'(b);
		end
		m = f << (4'd15 - top);
		cnt = 4'd0;
		for (int i = 0; i < NUM_CLASSES; i++) begin
			if (m >= note_edge(4'(i))) cnt = cnt + 4'd1;
		end
		if (cnt == 4'd12 || f == 16'd0) cnt = 4'd0;
		return cnt;
	endfunction

endpackage

/* hw/rtl/mke_in_if.sv */
`timescale 1ns / 1ps

interface mke_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] pitch_frequency;
	logic [15:0] pitch_confidence;

	modport source (output valid, output pitch_frequency, output pitch_confidence, input ready);
	modport sink (input valid, input pitch_frequency, input pitch_confidence, output ready);
endinterface

/* hw/rtl/mke_out_if.sv */
`timescale 1ns / 1ps

interface mke_out_if;
	logic       valid;
	logic       ready;
	logic [4:0] key_index;
	logic       key_updated;

	modport source (output valid, output key_index, output key_updated, input ready);
	modport sink (input valid, input key_index, input key_updated, output ready);
endinterface

/* hw/rtl/musical_key_estimator.sv */
`timescale 1ns / 1ps
// Musical key estimator.
// pitch: one pitch estimate per transfer (frequency in 1/64 Hz, confidence Q1.15).
// key:   one result per estimate: the current key (0-11 major, 12-23 minor,
//        24 none yet) and a flag that is set when this estimate recomputed the key.
// cfg:   register writes (threshold, frequency band, decay, minimum total),
//        taken at any edge with cfg_write_enable high; write only while idle.
// Sequence: an estimate that fails the gate gets its result straight from the
// idle state; one whose weight total stays below the minimum gets it after the
// decay pass over every bin. A full estimate runs the decay pass, the correlation
// pass (12 keys, one multiply-accumulate per profile per cycle, then a compare
// per key) and a final exact compare of the best major against the best minor
// on one shift-add multiplier.
// The block takes a new estimate only when idle and the result register is empty;
// a stalled receiver holds the result and with it the input side.
// Reset clears the weights, sets the key to none and loads register defaults.
module musical_key_estimator
	import mke_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write_enable,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mke_in_if.sink                pitch,
	mke_out_if.source             key
);

	state_t state_q, state_d;

	logic [15:0] conf_thresh_q, freq_low_q, freq_high_q, decay_q;
	logic [23:0] min_total_q;

	logic [23:0] w_q [NUM_CLASSES];
	logic [4:0]  key_q;
	logic [3:0]  pc_q;
	logic [15:0] conf_q;
	logic [3:0]  idx_q, rot_q;
	logic [27:0] total_q;
	logic [37:0] acc_maj_q, acc_min_q;
	logic [40:0] syt_maj_q, syt_min_q;
	logic signed [42:0] bmaj_n_q, bmin_n_q;
	logic [3:0]  bmaj_k_q, bmin_k_q;
	logic [107:0] mul_a_q, mul_acc_q, pmaj_q;
	logic [42:0] mul_b_q;
	logic [1:0]  ph_q;
	logic        out_valid_q, out_upd_q;
	logic [4:0]  out_key_q;

	logic accept, gate_ok;
	logic [39:0] dec_prod;
	logic [24:0] bin_sum;
	logic [23:0] bin_new;
	logic [4:0]  rsum;
	logic [3:0]  rix;
	logic [23:0] x;
	logic signed [42:0] nmaj, nmin;
	logic [42:0] abs_maj, abs_min;
	logic [1:0]  smaj, smin;
	logic        gt, eq, minor_wins;

	assign accept = pitch.valid && pitch.ready;
	assign gate_ok = pitch.pitch_confidence > conf_thresh_q
		&& pitch.pitch_frequency > freq_low_q && pitch.pitch_frequency < freq_high_q;

	assign dec_prod = w_q[idx_q] * decay_q;
	assign bin_sum = {1'b0, dec_prod[39:16]} + ((idx_q == pc_q) ? {8'd0, conf_q, 1'b0} : 25'd0);
	assign bin_new = bin_sum[24] ? WEIGHT_MAX : bin_sum[23:0];

	assign rsum = {1'b0, idx_q} + {1'b0, rot_q};
	assign rix = (rsum >= 5'd12) ? 4'(rsum - 5'd12) : rsum[3:0];
	assign x = w_q[rix];

	assign nmaj = $signed(43'({acc_maj_q, 3'b000}) + 43'({acc_maj_q, 2'b00}) - 43'(syt_maj_q));
	assign nmin = $signed(43'({acc_min_q, 3'b000}) + 43'({acc_min_q, 2'b00}) - 43'(syt_min_q));
	assign abs_maj = bmaj_n_q[42] ? 43'(-bmaj_n_q) : 43'(bmaj_n_q);
	assign abs_min = bmin_n_q[42] ? 43'(-bmin_n_q) : 43'(bmin_n_q);

	// sign as 0 = negative, 1 = zero, 2 = positive
	assign smaj = bmaj_n_q[42] ? 2'd0 : (bmaj_n_q == 43'sd0 ? 2'd1 : 2'd2);
	assign smin = bmin_n_q[42] ? 2'd0 : (bmin_n_q == 43'sd0 ? 2'd1 : 2'd2);

	always_comb begin
		gt = 1'b0;
		eq = 1'b0;
		if (smaj != smin) begin
			gt = smin > smaj;
		end else if (smin == 2'd1) begin
			eq = 1'b1;
		end else begin
			eq = mul_acc_q == pmaj_q;
			gt = (smin == 2'd2) ? (mul_acc_q > pmaj_q) : (mul_acc_q < pmaj_q);
		end
		minor_wins = gt || (eq && bmin_k_q < bmaj_k_q);
	end

	always_comb begin
		state_d = state_q;
		pitch.ready = (state_q == ST_IDLE) && !out_valid_q;
		case (state_q)
			ST_IDLE: if (accept && gate_ok) state_d = ST_DECAY;
			ST_DECAY: if (idx_q == 4'd11) state_d = ST_CHECK;
			ST_CHECK: state_d = (total_q >= 28'(min_total_q)) ? ST_MAC : ST_IDLE;
			ST_MAC: if (idx_q == 4'd11) state_d = ST_KEY;
			ST_KEY: state_d = (rot_q == 4'd11) ? ST_LOAD : ST_MAC;
			ST_LOAD: state_d = ST_MUL;
			ST_MUL: begin
				if (mul_b_q == 43'd0) state_d = (ph_q == 2'd3) ? ST_PICK : ST_LOAD;
			end
			ST_PICK: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign key.valid = out_valid_q;
	assign key.key_index = out_key_q;
	assign key.key_updated = out_upd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			conf_thresh_q <= 16'd18022;
			freq_low_q <= 16'd4480;
			freq_high_q <= 16'd60800;
			decay_q <= 16'd65208;
			min_total_q <= 24'd524288;
			for (int i = 0; i < NUM_CLASSES; i++) w_q[i] <= 24'd0;
			key_q <= NO_KEY;
			out_valid_q <= 1'b0;
			out_upd_q <= 1'b0;
			out_key_q <= NO_KEY;
			idx_q <= 4'd0;
			rot_q <= 4'd0;
			ph_q <= 2'd0;
		end else begin
			state_q <= state_d;
			if (cfg_write_enable) begin
				case (cfg_index)
					CFG_CONF_THRESH: conf_thresh_q <= cfg_data[15:0];
					CFG_FREQ_LOW: freq_low_q <= cfg_data[15:0];
					CFG_FREQ_HIGH: freq_high_q <= cfg_data[15:0];
					CFG_DECAY: decay_q <= cfg_data[15:0];
					CFG_MIN_TOTAL: min_total_q <= cfg_data;
					default: ;
				endcase
			end
			if (key.valid && key.ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pc_q <= pitch_class(pitch.pitch_frequency);
						conf_q <= pitch.pitch_confidence;
						idx_q <= 4'd0;
						total_q <= 28'd0;
						if (!gate_ok) begin
							out_valid_q <= 1'b1;
							out_upd_q <= 1'b0;
							out_key_q <= key_q;
						end
					end
				end
				ST_DECAY: begin
					w_q[idx_q] <= bin_new;
					total_q <= total_q + 28'(bin_new);
					idx_q <= (idx_q == 4'd11) ? 4'd0 : idx_q + 4'd1;
				end
				ST_CHECK: begin
					syt_maj_q <= 41'(total_q * MAJ_SUM);
					syt_min_q <= 41'(total_q * MIN_SUM);
					acc_maj_q <= 38'd0;
					acc_min_q <= 38'd0;
					idx_q <= 4'd0;
					rot_q <= 4'd0;
					ph_q <= 2'd0;
					if (total_q < 28'(min_total_q)) begin
						out_valid_q <= 1'b1;
						out_upd_q <= 1'b0;
						out_key_q <= key_q;
					end
				end
				ST_MAC: begin
					acc_maj_q <= acc_maj_q + 38'(x * major_w(idx_q));
					acc_min_q <= acc_min_q + 38'(x * minor_w(idx_q));
					idx_q <= (idx_q == 4'd11) ? 4'd0 : idx_q + 4'd1;
				end
				ST_KEY: begin
					// same spread within a profile: compare numerators directly
					if (rot_q == 4'd0 || nmaj > bmaj_n_q) begin
						bmaj_n_q <= nmaj;
						bmaj_k_q <= rot_q;
					end
					if (rot_q == 4'd0 || nmin > bmin_n_q) begin
						bmin_n_q <= nmin;
						bmin_k_q <= rot_q;
					end
					acc_maj_q <= 38'd0;
					acc_min_q <= 38'd0;
					rot_q <= rot_q + 4'd1;
				end
				ST_LOAD: begin
					// |n| * other spread, then times |n| again
					case (ph_q)
						2'd0: begin
							mul_a_q <= 108'(abs_maj);
							mul_b_q <= MIN_SPREAD;
						end
						2'd1: begin
							mul_a_q <= mul_acc_q;
							mul_b_q <= abs_maj;
						end
						2'd2: begin
							mul_a_q <= 108'(abs_min);
							mul_b_q <= MAJ_SPREAD;
						end
						default: begin
							mul_a_q <= mul_acc_q;
							mul_b_q <= abs_min;
						end
					endcase
					mul_acc_q <= 108'd0;
				end
				ST_MUL: begin
					if (mul_b_q == 43'd0) begin
						if (ph_q == 2'd1) pmaj_q <= mul_acc_q;
						ph_q <= ph_q + 2'd1;
					end else begin
						if (mul_b_q[0]) mul_acc_q <= mul_acc_q + mul_a_q;
						mul_a_q <= mul_a_q << 1;
						mul_b_q <= mul_b_q >> 1;
					end
				end
				ST_PICK: begin
					key_q <= minor_wins ? 5'(bmin_k_q) + 5'd12 : 5'(bmaj_k_q);
					out_key_q <= minor_wins ? 5'(bmin_k_q) + 5'd12 : 5'(bmaj_k_q);
					out_upd_q <= 1'b1;
					out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

class key_scoreboard;
	typedef struct packed {
		logic [4:0] key_index;
		logic       key_updated;
	} key_result_t;

	bit [15:0] edge_of_note[12] = '{34470, 36520, 38691, 40992, 43429, 46012,
		48748, 51646, 54717, 57971, 61418, 65070};
	longint major_hund[12] = '{635, 223, 348, 233, 438, 409, 252, 519, 239, 366, 229, 288};
	longint minor_hund[12] = '{633, 268, 352, 538, 260, 353, 254, 475, 398, 269, 334, 317};

	bit [23:0] weights[12];
	bit [4:0]  held_key;
	bit [15:0] conf_thresh;
	bit [15:0] freq_low;
	bit [15:0] freq_high;
	bit [15:0] decay;
	bit [23:0] min_total;
	key_result_t key_queue[$];
	int mismatches;

	function new();
		foreach (weights[i]) weights[i] = '0;
		held_key = mke_pkg::NO_KEY;
		conf_thresh = 16'd18022;
		freq_low = 16'd4480;
		freq_high = 16'd60800;
		decay = 16'd65208;
		min_total = 24'd524288;
		mismatches = 0;
	endfunction

	function void set_reg(mke_pkg::cfg_idx_t idx, bit [23:0] v);
		case (idx)
			mke_pkg::CFG_CONF_THRESH: conf_thresh = v[15:0];
			mke_pkg::CFG_FREQ_LOW:    freq_low = v[15:0];
			mke_pkg::CFG_FREQ_HIGH:   freq_high = v[15:0];
			mke_pkg::CFG_DECAY:       decay = v[15:0];
			mke_pkg::CFG_MIN_TOTAL:   min_total = v;
			default: ;
		endcase
	endfunction

	function int note_class(bit [15:0] f);
		int top;
		bit [15:0] m;
		int cnt;
		if (f == 0) return 0;
		top = 15;
		while (!f[top]) top--;
		m = f << (15 - top);
		cnt = 0;
		foreach (edge_of_note[i]) if (m >= edge_of_note[i]) cnt++;
		return cnt % 12;
	endfunction

	function longint spread(longint p[12]);
		longint s, ss;
		s = 0;
		ss = 0;
		foreach (p[i]) begin
			s += p[i];
			ss += p[i] * p[i];
		end
		return 12 * ss - s * s;
	endfunction

	function longint corr_num(longint p[12], int rot, longint sx);
		longint sy, sxy;
		sy = 0;
		sxy = 0;
		for (int i = 0; i < 12; i++) begin
			sy += p[i];
			sxy += longint'(weights[(i + rot) % 12]) * p[i];
		end
		return 12 * sxy - sx * sy;
	endfunction

	// compare na/sqrt(da) against nb/sqrt(db) exactly
	function bit corr_above(longint na, longint da, longint nb, longint db);
		int sa, sb;
		bit [127:0] ma, mb, lhs, rhs;
		sa = (na > 0) - (na < 0);
		sb = (nb > 0) - (nb < 0);
		if (sa != sb) return sa > sb;
		if (sa == 0) return 0;
		ma = (na < 0) ? -na : na;
		mb = (nb < 0) ? -nb : nb;
		lhs = ma * ma * 128'(db);
		rhs = mb * mb * 128'(da);
		return (sa > 0) ? (lhs > rhs) : (lhs < rhs);
	endfunction

	function void note_estimate(bit [15:0] f, bit [15:0] c);
		key_result_t r;
		int pc;
		longint total, dmaj, dmin, nmaj, nmin, best_n, best_d;
		bit [24:0] sum;
		int best;
		r.key_updated = 0;
		if (c > conf_thresh && f > freq_low && f < freq_high) begin
			pc = note_class(f);
			foreach (weights[i]) weights[i] = 24'((40'(weights[i]) * decay) >> 16);
			sum = 25'(weights[pc]) + 25'({c, 1'b0});
			weights[pc] = sum[24] ? 24'hFFFFFF : sum[23:0];
			total = 0;
			foreach (weights[i]) total += weights[i];
			if (total >= min_total) begin
				dmaj = spread(major_hund);
				dmin = spread(minor_hund);
				best_n = 0;
				best_d = 1;
				best = 0;
				for (int k = 0; k < 12; k++) begin
					nmaj = corr_num(major_hund, k, total);
					nmin = corr_num(minor_hund, k, total);
					if (k == 0 || corr_above(nmaj, dmaj, best_n, best_d)) begin
						best_n = nmaj;
						best_d = dmaj;
						best = k;
					end
					if (corr_above(nmin, dmin, best_n, best_d)) begin
						best_n = nmin;
						best_d = dmin;
						best = k + 12;
					end
				end
				held_key = 5'(best);
				r.key_updated = 1;
			end
		end
		r.key_index = held_key;
		key_queue.push_back(r);
	endfunction

	function void check_key(bit [4:0] k, bit u);
		key_result_t e;
		if (key_queue.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result: key %0d updated %0b", k, u);
			return;
		end
		e = key_queue.pop_front();
		if (e.key_index !== k || e.key_updated !== u) begin
			mismatches++;
			if (mismatches <= 10)
				$display("key mismatch: expected %0d/%0b, got %0d/%0b",
					e.key_index, e.key_updated, k, u);
		end
	endfunction
endclass

module testbench;
	import mke_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_enable;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	bit                    no_idle;
	int                    hold_left;

	mke_in_if  pitch_ch ();
	mke_out_if key_ch ();

	key_scoreboard sb = new();

	musical_key_estimator uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_enable(cfg_write_enable),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pitch(pitch_ch.sink),
		.key(key_ch.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		key_ch.ready = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				key_ch.ready <= 0;
			end else begin
				key_ch.ready <= no_idle || ($urandom_range(99) >= 22);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pitch_ch.valid && pitch_ch.ready)
				sb.note_estimate(pitch_ch.pitch_frequency, pitch_ch.pitch_confidence);
			if (key_ch.valid && key_ch.ready)
				sb.check_key(key_ch.key_index, key_ch.key_updated);
		end
	end

	task automatic send_estimate(bit [15:0] f, bit [15:0] c);
		if (!no_idle && $urandom_range(99) < 22) begin
			pitch_ch.valid <= 0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		pitch_ch.valid <= 1;
		pitch_ch.pitch_frequency <= f;
		pitch_ch.pitch_confidence <= c;
		do @(posedge clk); while (!pitch_ch.ready);
	endtask

	task automatic drain();
		@(posedge clk);
		pitch_ch.valid <= 0;
		while (sb.key_queue.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [23:0] v);
		@(posedge clk);
		cfg_write_enable <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write_enable <= 0;
		sb.set_reg(idx, v);
	endtask

	// mostly in-band, confident estimates; the rest raw noise
	task automatic send_random(int n);
		bit [15:0] f, c;
		repeat (n) begin
			if ($urandom_range(99) < 75 && sb.freq_high > sb.freq_low + 1 &&
					sb.conf_thresh < 16'hFFFF) begin
				f = 16'($urandom_range(sb.freq_high - 1, sb.freq_low + 1));
				c = 16'((sb.conf_thresh < 32768) ?
					$urandom_range(32768, sb.conf_thresh + 1) :
					$urandom_range(16'hFFFF, sb.conf_thresh + 1));
			end else begin
				f = 16'($urandom());
				c = 16'($urandom());
			end
			send_estimate(f, c);
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_write_enable = 0;
		cfg_index = '0;
		cfg_data = '0;
		pitch_ch.valid = 0;
		pitch_ch.pitch_frequency = '0;
		pitch_ch.pitch_confidence = '0;
		no_idle = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// gate edges at reset defaults, zero and full-scale fields
		send_estimate(16'd27000, 16'd18022);
		send_estimate(16'd27000, 16'd18023);
		send_estimate(16'd4480, 16'd30000);
		send_estimate(16'd4481, 16'd30000);
		send_estimate(16'd60800, 16'd30000);
		send_estimate(16'd60799, 16'd30000);
		send_estimate(16'd0, 16'd32768);
		send_estimate(16'hFFFF, 16'hFFFF);
		send_estimate(16'd28160, 16'd0);
		// walk every class until the total crosses the minimum
		for (int i = 0; i < 12; i++) send_estimate(sb.edge_of_note[i] >> 1, 16'd32768);
		send_estimate(sb.edge_of_note[11] - 16'd1, 16'd32768);
		drain();

		// widest gate, weights wiped every update
		write_reg(CFG_CONF_THRESH, 24'd0);
		write_reg(CFG_FREQ_LOW, 24'd0);
		write_reg(CFG_FREQ_HIGH, 24'd65535);
		write_reg(CFG_DECAY, 24'd0);
		write_reg(CFG_MIN_TOTAL, 24'd0);
		send_estimate(16'd1, 16'd1);
		send_random(120);
		drain();

		// slowest decay: saturate one bin on the fast path, then estimate
		write_reg(CFG_DECAY, 24'd65535);
		write_reg(CFG_MIN_TOTAL, 24'hFFFFFF);
		repeat (135) send_estimate(16'd28160, 16'hFFFF);
		send_random(30);
		drain();
		write_reg(CFG_MIN_TOTAL, 24'd1);
		send_random(40);
		drain();

		// threshold raised to 32768; confident in-band estimates still pass
		write_reg(CFG_CONF_THRESH, 24'd32768);
		send_random(40);
		drain();

		// defaults again, with a long receiver stall
		write_reg(CFG_CONF_THRESH, 24'd18022);
		write_reg(CFG_FREQ_LOW, 24'd4480);
		write_reg(CFG_FREQ_HIGH, 24'd60800);
		write_reg(CFG_DECAY, 24'd65208);
		write_reg(CFG_MIN_TOTAL, 24'd524288);
		hold_left = 3000;
		send_random(120);
		no_idle = 1;
		send_random(80);
		no_idle = 0;
		drain();

		// random settings
		repeat (4) begin
			write_reg(CFG_CONF_THRESH, 24'($urandom_range(30000)));
			write_reg(CFG_FREQ_LOW, 24'($urandom_range(8000)));
			write_reg(CFG_FREQ_HIGH, 24'($urandom_range(65535, 30000)));
			write_reg(CFG_DECAY, 24'($urandom_range(65535, 50000)));
			write_reg(CFG_MIN_TOTAL, 24'($urandom_range(2000000)));
			send_random(30);
			drain();
		end

		repeat (400) @(posedge clk);
		if (sb.mismatches == 0 && sb.key_queue.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

/* musical_key_estimator.f */
hw/rtl/mke_pkg.sv
hw/rtl/mke_in_if.sv
hw/rtl/mke_out_if.sv
hw/rtl/musical_key_estimator.sv
sim/testbench.sv
